// ===== design/assert_macros.svh =====
// assertion macros used by the checker file kwm_checker.sv
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define KWM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kwm assertion failed");

// next-cycle implication, off during reset
`define KWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kwm assertion failed");

// next-cycle implication, also checked across reset
`define KWM_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("kwm assertion failed");

`endif

// ===== design/kwm_pkg.sv =====
// shared constants, types and state encoding of the k-way merge
// used by kwm_ctrl, kwm_dp and the top level; depends on nothing
package kwm_pkg;

    localparam int LANES       = 16;
    localparam int VALUE_BITS  = 32;
    localparam int LANE_FW     = 4;
    localparam int CFG_W       = 5;
    localparam int LANE_W      = $clog2(LANES);
    localparam int TREE_LEVELS = $clog2(LANES);
    localparam int TREE_SIZE   = 1 << TREE_LEVELS;
    localparam int LEVEL_W     = $clog2(TREE_LEVELS + 1);

    localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(LANES);
    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(TREE_LEVELS - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic reduce;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic lanes_ready;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic                  vld;
        logic [VALUE_BITS-1:0] val;
        logic [LANE_W-1:0]     idx;
    } t_cand;

endpackage

// ===== design/kwm_ctrl.sv =====
// controller state machine of the k-way merge
// drives datapath commands from kwm_pkg::t_dp_cmd, reads kwm_pkg::t_dp_sts
module kwm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kwm_pkg::t_dp_sts  i_sts,
    output kwm_pkg::t_dp_cmd  o_cmd
);

    kwm_pkg::t_state                  r_state;
    kwm_pkg::t_state                  n_state;
    logic [kwm_pkg::LEVEL_W-1:0]      r_level;
    logic [kwm_pkg::LEVEL_W-1:0]      n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::ST_IDLE;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_level    = r_level;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            kwm_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = kwm_pkg::ST_CHECK;
                end
            end
            kwm_pkg::ST_CHECK: begin
                if (i_sts.lanes_ready) begin
                    o_cmd.load = 1'b1;
                    n_level    = '0;
                    n_state    = kwm_pkg::ST_REDUCE;
                end else begin
                    n_state = kwm_pkg::ST_IDLE;
                end
            end
            kwm_pkg::ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (r_level == kwm_pkg::LAST_LEVEL) begin
                    n_level = '0;
                    n_state = kwm_pkg::ST_EMIT;
                end else begin
                    n_level = r_level + kwm_pkg::LEVEL_ONE;
                end
            end
            kwm_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = kwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kwm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/kwm_dp.sv =====
// datapath of the k-way merge: lane heads, tournament tree, output register
// uses kwm_pkg constants and the command and status structs
module kwm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic [kwm_pkg::VALUE_BITS-1:0]    i_in_value,
    input  logic [kwm_pkg::LANE_FW-1:0]       i_in_lane,
    input  logic                              i_in_end,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [kwm_pkg::VALUE_BITS-1:0]    o_out_value,
    output logic [kwm_pkg::LANE_FW-1:0]       o_out_lane,
    output logic                              o_out_done,
    input  kwm_pkg::t_dp_cmd                  i_cmd,
    output kwm_pkg::t_dp_sts                  o_sts
);

    logic [kwm_pkg::CFG_W-1:0]       r_cfg;
    logic [kwm_pkg::CFG_W-1:0]       used;
    logic [kwm_pkg::VALUE_BITS-1:0]  r_head_val [kwm_pkg::LANES];
    logic [kwm_pkg::LANES-1:0]       r_head_vld;
    logic [kwm_pkg::LANES-1:0]       r_exh;
    kwm_pkg::t_cand                  r_cand [kwm_pkg::TREE_SIZE];
    kwm_pkg::t_cand                  n_cand [kwm_pkg::TREE_SIZE];
    logic                            r_out_valid;
    logic [kwm_pkg::VALUE_BITS-1:0]  r_out_value;
    logic [kwm_pkg::LANE_FW-1:0]     r_out_lane;
    logic                            r_out_done;
    logic [kwm_pkg::LANE_W-1:0]      in_idx;
    logic                            in_take;
    logic                            ready_all;

    // lower lane wins ties, so the right side wins only when strictly smaller
    function automatic kwm_pkg::t_cand pick(input kwm_pkg::t_cand a, input kwm_pkg::t_cand b);
        if (b.vld && (!a.vld || ($signed(b.val) < $signed(a.val)))) begin
            return b;
        end
        return a;
    endfunction

    always_comb begin
        used = r_cfg;
        if (r_cfg == '0) begin
            used = kwm_pkg::CFG_W'(1);
        end else if (r_cfg > kwm_pkg::CFG_RESET) begin
            used = kwm_pkg::CFG_RESET;
        end
    end

    assign in_idx  = i_in_lane[kwm_pkg::LANE_W-1:0];
    assign in_take = i_cmd.accept && ({1'b0, i_in_lane} < used)
                     && !r_head_vld[in_idx] && !r_exh[in_idx];

    always_comb begin
        ready_all = 1'b1;
        for (int i = 0; i < kwm_pkg::LANES; i++) begin
            if ((kwm_pkg::CFG_W'(i) < used) && !r_head_vld[i] && !r_exh[i]) begin
                ready_all = 1'b0;
            end
        end
    end

    assign o_sts.lanes_ready = ready_all;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    // tree leaves on load, one level of pairwise picks per reduce step
    always_comb begin
        for (int i = 0; i < kwm_pkg::TREE_SIZE; i++) begin
            n_cand[i] = r_cand[i];
        end
        if (i_cmd.load) begin
            for (int i = 0; i < kwm_pkg::TREE_SIZE; i++) begin
                n_cand[i].idx = kwm_pkg::LANE_W'(i);
                if (i < kwm_pkg::LANES) begin
                    n_cand[i].vld = r_head_vld[i] && (kwm_pkg::CFG_W'(i) < used);
                    n_cand[i].val = r_head_val[i];
                end else begin
                    n_cand[i].vld = 1'b0;
                    n_cand[i].val = '0;
                end
            end
        end else if (i_cmd.reduce) begin
            for (int i = 0; i < kwm_pkg::TREE_SIZE / 2; i++) begin
                n_cand[i] = pick(r_cand[2*i], r_cand[2*i+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= kwm_pkg::CFG_RESET;
            r_head_vld  <= '0;
            r_exh       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (in_take) begin
                if (i_in_end) begin
                    r_exh[in_idx] <= 1'b1;
                end else begin
                    r_head_vld[in_idx] <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_cand[0].vld) begin
                    r_head_vld[r_cand[0].idx] <= 1'b0;
                end else begin
                    r_head_vld <= '0;
                    r_exh      <= '0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && !i_in_end) begin
            r_head_val[in_idx] <= i_in_value;
        end
        for (int i = 0; i < kwm_pkg::TREE_SIZE; i++) begin
            r_cand[i] <= n_cand[i];
        end
        if (i_cmd.emit) begin
            r_out_done  <= !r_cand[0].vld;
            r_out_value <= r_cand[0].vld ? r_cand[0].val : '0;
            r_out_lane  <= r_cand[0].vld ? r_cand[0].idx : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_lane  = r_out_lane;
    assign o_out_done  = r_out_done;

endmodule

// ===== design/k_way_sorted_stream_merge.sv =====
// top level of the k-way sorted stream merge
// instantiates kwm_ctrl and kwm_dp, types from kwm_pkg
//
// channel   dir  tdata            tuser             tlast
// s_axis    in   value [31:0]     lane [3:0]        lane_end
// m_axis    out  merged_value     source_lane [3:0] merge_done
// cfg       in   lanes_in_use [4:0] on i_cfg_wdata, written when i_cfg_we is high
//
// one beat at a time: accept, then the lane check, then if every lane in use
// holds a head or is exhausted, log2(LANES) tree levels (4) and the emit
// emit waits while m_axis stalls
// synchronous active-low reset: lanes_in_use back to 16, all heads and ends cleared
module k_way_sorted_stream_merge (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // value
    input  logic [3:0]   s_axis_tuser,   // lane
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // merged_value
    output logic [3:0]   m_axis_tuser,   // source_lane
    output logic         m_axis_tlast
);

    kwm_pkg::t_dp_cmd cmd;
    kwm_pkg::t_dp_sts sts;

    kwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kwm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_value  (s_axis_tdata),
        .i_in_lane   (s_axis_tuser),
        .i_in_end    (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (m_axis_tdata),
        .o_out_lane  (m_axis_tuser),
        .o_out_done  (m_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== design/kwm_checker.sv =====
// port-level checks of k_way_sorted_stream_merge, bound to the top level
// uses the macros of assert_macros.svh
`include "assert_macros.svh"

module kwm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_cfg_we,
    input logic [4:0]   i_cfg_wdata,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [31:0]  s_axis_tdata,
    input logic [3:0]   s_axis_tuser,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic [3:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // stalled output beat holds
    `KWM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    // done beat carries zero value and lane
    `KWM_ASSERT_NOW(a_done_zero, m_axis_tvalid && m_axis_tlast,
        (m_axis_tdata == 32'd0) && (m_axis_tuser == 4'd0))
    // one beat at a time: the lane check follows every accepted beat
    `KWM_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // reset empties the output register
    `KWM_ASSERT_RST(a_rst_out, !i_rst_n, !m_axis_tvalid)

endmodule

bind k_way_sorted_stream_merge kwm_checker u_kwm_checker (.*);
